@@ sv/sssr_pkg.sv @@
`timescale 1ns / 1ps

package sssr_pkg;

   localparam int DEF_GRID_COLS = 40;
   localparam int DEF_GRID_ROWS = 32;
   localparam int MAX_COLS      = 40;
   localparam int MAX_ROWS      = 32;

   localparam int MASK_W   = 40;
   localparam int ROW_W    = 5;
   localparam int STATUS_W = 2;
   localparam int CSR_W    = 6;
   localparam int CSR_IDX_W = 1;
   localparam int SIDE_W   = 7;
   localparam int COORD_IN_W = 8;

   // Coordinate and edge-value widths.
   localparam int CW = 11;
   localparam int EW = 24;

   // Iterative divider and square root.
   localparam int DIV_W  = 16;
   localparam int ITER_W = 4;
   localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(DIV_W - 1);

   localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_INVALID = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY   = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_GRID_HEIGHT = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_WIDTH  = 1'd1;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,
      OP_SQA,
      OP_SQB,
      OP_SQC,
      OP_AB,
      OP_N,
      OP_T1,
      OP_NN,
      OP_NX,
      OP_DY,
      OP_DYSQ,
      OP_D,
      OP_DIVX_INIT,
      OP_DIV_STEP,
      OP_X3,
      OP_SQRT_INIT,
      OP_SQRT_STEP,
      OP_DIVY_INIT,
      OP_Y3,
      OP_FULL,
      OP_C1,
      OP_C2A,
      OP_C2B,
      OP_C3A,
      OP_C3B,
      OP_BOX,
      OP_E1,
      OP_E2,
      OP_E3,
      OP_ROW_NEXT,
      OP_ROW_RESTART
   } op_type;

   // Output loads are separate commands so they stay out of the program.
   typedef enum logic [1:0] {
      EMIT_NONE,
      EMIT_ROW,
      EMIT_INVALID,
      EMIT_EMPTY
   } emit_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_RUN,
      ST_SCAN,
      ST_EMIT,
      ST_INVALID,
      ST_EMPTY
   } state_type;

   typedef struct packed {
      op_type   op;
      emit_type emit;
   } dp_cmd_type;

   typedef struct packed {
      logic invalid;
      logic empty;
      logic row_last;
      logic row_nonzero;
      logic out_free;
   } dp_status_type;

   localparam int PC_W = 5;
   localparam logic [PC_W-1:0] PC_LAST = 5'd28;

   function automatic op_type prog_op(input logic [PC_W-1:0] pc);
      op_type o;
      case (pc)
         5'd0:  o = OP_SQA;
         5'd1:  o = OP_SQB;
         5'd2:  o = OP_SQC;
         5'd3:  o = OP_AB;
         5'd4:  o = OP_N;
         5'd5:  o = OP_T1;
         5'd6:  o = OP_NN;
         5'd7:  o = OP_NX;
         5'd8:  o = OP_DY;
         5'd9:  o = OP_DYSQ;
         5'd10: o = OP_D;
         5'd11: o = OP_DIVX_INIT;
         5'd12: o = OP_DIV_STEP;
         5'd13: o = OP_X3;
         5'd14: o = OP_SQRT_INIT;
         5'd15: o = OP_SQRT_STEP;
         5'd16: o = OP_DIVY_INIT;
         5'd17: o = OP_DIV_STEP;
         5'd18: o = OP_Y3;
         5'd19: o = OP_FULL;
         5'd20: o = OP_C1;
         5'd21: o = OP_C2A;
         5'd22: o = OP_C2B;
         5'd23: o = OP_C3A;
         5'd24: o = OP_C3B;
         5'd25: o = OP_BOX;
         5'd26: o = OP_E1;
         5'd27: o = OP_E2;
         5'd28: o = OP_E3;
         default: o = OP_NONE;
      endcase
      return o;
   endfunction

   function automatic logic [EW-1:0] mag(input logic signed [EW-1:0] v);
      return v[EW-1] ? EW'(-v) : EW'(v);
   endfunction

endpackage

@@ sv/sss_triangle_row_rasterizer_core.sv @@
`timescale 1ns / 1ps

// Triangle row rasterizer, side-side-side form.
// The request channel (req_*) takes one draw word: an origin and three side
// lengths. The response channel (rsp_*) returns the coverage words of that
// command in rising row order, one per clipped grid row, with rsp_last set on
// the final one. Sides that fail the triangle inequality give a single word
// with status 1, and a triangle with no covered pixel in the grid gives a
// single word with status 2.
// Setup runs the shared multiplier sequence and three 16-step iterative
// passes (two divides on one divider, one square root); a scan of the clipped
// rows then finds, one row per cycle, whether anything is covered, and the
// emit follows, one row per cycle while the response is not stalled. The
// block takes one command at a time; req_stall stays high until the last word
// of the current command is loaded into the output register. A stalled
// response holds its word and pauses the emit sequence. Reset is synchronous
// and sets grid_height to 32 and grid_width to 40. The user must write those
// two registers through the csr_* port only while idle; it is not enforced.

module sss_triangle_row_rasterizer_core import sssr_pkg::*; #(
   parameter int GRID_COLS = DEF_GRID_COLS,
   parameter int GRID_ROWS = DEF_GRID_ROWS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [COORD_IN_W-1:0] req_origin_x,
   input  logic signed [COORD_IN_W-1:0] req_origin_y,
   input  logic [SIDE_W-1:0]            req_side_a,
   input  logic [SIDE_W-1:0]            req_side_b,
   input  logic [SIDE_W-1:0]            req_side_c,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [STATUS_W-1:0]          rsp_status,
   output logic [ROW_W-1:0]             rsp_row_index,
   output logic [MASK_W-1:0]            rsp_row_mask,
   output logic                         rsp_last,
   input  logic                         csr_wr_en,
   input  logic [CSR_IDX_W-1:0]         csr_index,
   input  logic [CSR_W-1:0]             csr_data
);

   dp_cmd_type    cmd;
   dp_status_type status;

   sssr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   sssr_datapath #(
      .GRID_COLS (GRID_COLS),
      .GRID_ROWS (GRID_ROWS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_origin_x  (req_origin_x),
      .req_origin_y  (req_origin_y),
      .req_side_a    (req_side_a),
      .req_side_b    (req_side_b),
      .req_side_c    (req_side_c),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_status    (rsp_status),
      .rsp_row_index (rsp_row_index),
      .rsp_row_mask  (rsp_row_mask),
      .rsp_last      (rsp_last)
   );

endmodule

@@ sv/sssr_ctrl.sv @@
`timescale 1ns / 1ps

module sssr_ctrl import sssr_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   state_type         state_ff, state_in;
   logic [PC_W-1:0]   pc_ff, pc_in;
   logic [ITER_W-1:0] it_ff, it_in;
   logic              any_ff, any_in;
   op_type            prog;

   assign prog = prog_op(pc_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pc_ff    <= '0;
         it_ff    <= '0;
         any_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         pc_ff    <= pc_in;
         it_ff    <= it_in;
         any_ff   <= any_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      pc_in     = pc_ff;
      it_in     = it_ff;
      any_in    = any_ff;
      cmd.op    = OP_NONE;
      cmd.emit  = EMIT_NONE;
      req_stall = (state_ff != ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.invalid) begin
               state_in = ST_INVALID;
            end else begin
               state_in = ST_RUN;
               pc_in    = '0;
               it_in    = '0;
            end
         end
         ST_RUN: begin
            cmd.op = prog;
            if ((prog == OP_DIV_STEP || prog == OP_SQRT_STEP) && it_ff != ITER_LAST) begin
               it_in = it_ff + 1'b1;
            end else begin
               it_in = '0;
               if (pc_ff == PC_LAST) begin
                  any_in   = 1'b0;
                  state_in = status.empty ? ST_EMPTY : ST_SCAN;
               end else begin
                  pc_in = pc_ff + 1'b1;
               end
            end
         end
         ST_SCAN: begin
            any_in = any_ff || status.row_nonzero;
            if (status.row_last) begin
               if (any_ff || status.row_nonzero) begin
                  cmd.op   = OP_ROW_RESTART;
                  state_in = ST_EMIT;
               end else begin
                  state_in = ST_EMPTY;
               end
            end else begin
               cmd.op = OP_ROW_NEXT;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.op   = OP_ROW_NEXT;
               cmd.emit = EMIT_ROW;
               if (status.row_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_INVALID: begin
            if (status.out_free) begin
               cmd.emit = EMIT_INVALID;
               state_in = ST_IDLE;
            end
         end
         ST_EMPTY: begin
            if (status.out_free) begin
               cmd.emit = EMIT_EMPTY;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // The iteration count only runs while the program sits on a stepping command.
   a_iter_on_step: assert property (@(posedge clock) disable iff (reset)
      (it_ff != '0) |-> (state_ff == ST_RUN && (prog == OP_DIV_STEP || prog == OP_SQRT_STEP)))
      else $error("iteration count outside a stepping command");

endmodule

@@ sv/sssr_datapath.sv @@
`timescale 1ns / 1ps

module sssr_datapath import sssr_pkg::*; #(
   parameter int GRID_COLS = DEF_GRID_COLS,
   parameter int GRID_ROWS = DEF_GRID_ROWS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  dp_cmd_type                   cmd,
   output dp_status_type                status,
   input  logic signed [COORD_IN_W-1:0] req_origin_x,
   input  logic signed [COORD_IN_W-1:0] req_origin_y,
   input  logic [SIDE_W-1:0]            req_side_a,
   input  logic [SIDE_W-1:0]            req_side_b,
   input  logic [SIDE_W-1:0]            req_side_c,
   input  logic                         csr_wr_en,
   input  logic [CSR_IDX_W-1:0]         csr_index,
   input  logic [CSR_W-1:0]             csr_data,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [STATUS_W-1:0]          rsp_status,
   output logic [ROW_W-1:0]             rsp_row_index,
   output logic [MASK_W-1:0]            rsp_row_mask,
   output logic                         rsp_last
);

   localparam int LANES   = (GRID_COLS < MAX_COLS) ? GRID_COLS : MAX_COLS;
   localparam int ROW_CAP = (GRID_ROWS < MAX_ROWS) ? GRID_ROWS : MAX_ROWS;

   logic [CSR_W-1:0] gh_ff, gw_ff;
   logic             rsp_valid_ff;

   logic signed [COORD_IN_W-1:0] x1_ff, y1_ff;
   logic [SIDE_W-1:0]   a_ff, b_ff, c_ff;
   logic [13:0]         sqa_ff, sqb_ff, sqc_ff, ab_ff;
   logic signed [16:0]  n_ff, dy_ff;
   logic [31:0]         t1_ff, nn_ff, dysq_ff, d_ff;
   logic signed [17:0]  numx_ff;
   logic                numx_neg_ff;
   logic [DIV_W-1:0]    dq_ff;
   logic [7:0]          dr_ff;
   logic [31:0]         sq_src_ff;
   logic [18:0]         sq_rem_ff;
   logic [DIV_W-1:0]    sq_root_ff;
   logic signed [CW-1:0] x3_ff, y3_ff;
   logic [16:0]         full_ff;
   logic signed [EW-1:0] tmp_ff, c1_ff, c2_ff, c3_ff;
   logic signed [EW-1:0] b1s_ff, b2s_ff, b3s_ff;
   logic signed [EW-1:0] e1_ff, e2_ff, e3_ff;
   logic signed [CW-1:0] r0_ff, r1_ff, c0_ff, cl1_ff;
   logic                empty_ff;
   logic [ROW_W-1:0]    py_ff;
   logic [STATUS_W-1:0] st_ff;
   logic [ROW_W-1:0]    row_ff;
   logic [MASK_W-1:0]   mask_ff;
   logic                last_ff;

   logic signed [17:0]   mul_x, mul_y;
   logic signed [35:0]   mul_p;
   logic [7:0]           den;
   logic signed [CW-1:0] x1, y1, x2, dyy;
   logic signed [CW-1:0] b2, b3, a2, a3;
   logic [8:0]           sh;
   logic                 sh_ge;
   logic [18:0]          r4, trial;
   logic [8:0]           ce;
   logic                 inexact, ycond;
   logic signed [32:0]   ddiff;
   logic [6:0]           rows_use, cols_use;
   logic signed [CW-1:0] rlim, clim, ymin, ymax, xmin, xmax, r0, r1, c0, c1;
   logic [MASK_W-1:0]    mask_w;
   logic                 row_last, out_free;

   assign den = {a_ff, 1'b0};
   assign x1  = CW'(x1_ff);
   assign y1  = CW'(y1_ff);
   assign x2  = x1 + $signed(CW'(a_ff));
   assign dyy = y1 - y3_ff;
   assign b2  = x3_ff - x2;
   assign b3  = x1 - x3_ff;
   assign a2  = y1 - y3_ff;
   assign a3  = y3_ff - y1;

   always_comb begin
      mul_x = '0;
      mul_y = '0;
      case (cmd.op)
         OP_SQA: begin mul_x = 18'(a_ff); mul_y = 18'(a_ff); end
         OP_SQB: begin mul_x = 18'(b_ff); mul_y = 18'(b_ff); end
         OP_SQC: begin mul_x = 18'(c_ff); mul_y = 18'(c_ff); end
         OP_AB:  begin mul_x = 18'(a_ff); mul_y = 18'(b_ff); end
         OP_T1:  begin mul_x = 18'(ab_ff); mul_y = 18'(ab_ff); end
         OP_NN:  begin mul_x = 18'(n_ff); mul_y = 18'(n_ff); end
         OP_NX:  begin mul_x = 18'(den); mul_y = 18'(x1_ff); end
         OP_DY:  begin mul_x = 18'(den); mul_y = 18'(y1_ff); end
         OP_DYSQ: begin mul_x = 18'(dy_ff); mul_y = 18'(dy_ff); end
         OP_FULL: begin mul_x = 18'(a_ff); mul_y = 18'(dyy); end
         OP_C1:  begin mul_x = 18'(a_ff); mul_y = 18'(y1); end
         OP_C2A: begin mul_x = 18'(x2); mul_y = 18'(y3_ff); end
         OP_C2B: begin mul_x = 18'(x3_ff); mul_y = 18'(y1); end
         OP_C3A: begin mul_x = 18'(x3_ff); mul_y = 18'(y1); end
         OP_C3B: begin mul_x = 18'(x1); mul_y = 18'(y3_ff); end
         OP_E1:  begin mul_x = 18'(a_ff); mul_y = 18'(r0_ff); end
         OP_E2:  begin mul_x = 18'(b2); mul_y = 18'(r0_ff); end
         OP_E3:  begin mul_x = 18'(b3); mul_y = 18'(r0_ff); end
         default: begin
            mul_x = '0;
            mul_y = '0;
         end
      endcase
   end

   assign mul_p = mul_x * mul_y;

   assign sh    = {dr_ff, dq_ff[DIV_W-1]};
   assign sh_ge = (sh >= {1'b0, den});
   assign r4    = {sq_rem_ff[16:0], sq_src_ff[31:30]};
   assign trial = {1'b0, sq_root_ff, 2'b01};

   assign inexact = (sq_rem_ff != '0) || (dr_ff != '0);
   assign ce      = 9'(dq_ff[7:0]) + 9'(inexact);
   assign ycond   = !y1_ff[COORD_IN_W-1] && (d_ff <= dysq_ff);
   assign ddiff   = $signed({1'b0, t1_ff}) - $signed({1'b0, nn_ff});

   assign rows_use = ({1'b0, gh_ff} < 7'(ROW_CAP)) ? {1'b0, gh_ff} : 7'(ROW_CAP);
   assign cols_use = ({1'b0, gw_ff} < 7'(LANES)) ? {1'b0, gw_ff} : 7'(LANES);
   assign rlim = $signed(CW'(rows_use)) - $signed(CW'(1));
   assign clim = $signed(CW'(cols_use)) - $signed(CW'(1));
   assign ymin = (y1 < y3_ff) ? y1 : y3_ff;
   assign ymax = (y1 > y3_ff) ? y1 : y3_ff;
   assign xmin = (x1 < x3_ff) ? x1 : x3_ff;
   assign xmax = (x2 > x3_ff) ? x2 : x3_ff;
   assign r0 = (ymin < 0) ? '0 : ymin;
   assign r1 = (ymax < rlim) ? ymax : rlim;
   assign c0 = (xmin < 0) ? '0 : xmin;
   assign c1 = (xmax < clim) ? xmax : clim;

   for (genvar col = 0; col < LANES; col++) begin : g_lane
      localparam logic signed [EW-1:0] COL_E = EW'(col);
      localparam logic signed [CW-1:0] COL_C = CW'(col);
      logic signed [EW-1:0] e2l, e3l;
      logic [EW+1:0]        sum;
      assign e2l = e2_ff + EW'(a2) * COL_E;
      assign e3l = e3_ff + EW'(a3) * COL_E;
      assign sum = (EW+2)'(mag(e1_ff)) + (EW+2)'(mag(e2l)) + (EW+2)'(mag(e3l));
      assign mask_w[col] = (COL_C >= c0_ff) && (COL_C <= cl1_ff) &&
                           (sum == (EW+2)'(full_ff));
   end
   if (LANES < MASK_W) begin : g_pad
      assign mask_w[MASK_W-1:LANES] = '0;
   end

   assign row_last = (py_ff == r1_ff[ROW_W-1:0]);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   assign status.invalid = ({1'b0, a_ff} + {1'b0, b_ff} <= {1'b0, c_ff}) ||
                           ({1'b0, a_ff} + {1'b0, c_ff} <= {1'b0, b_ff}) ||
                           ({1'b0, b_ff} + {1'b0, c_ff} <= {1'b0, a_ff});
   assign status.empty       = empty_ff;
   assign status.row_last    = row_last;
   assign status.row_nonzero = (mask_w != '0);
   assign status.out_free    = out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         gh_ff        <= CSR_W'(MAX_ROWS);
         gw_ff        <= CSR_W'(MAX_COLS);
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en && csr_index == CSR_GRID_HEIGHT) begin
            gh_ff <= csr_data;
         end
         if (csr_wr_en && csr_index == CSR_GRID_WIDTH) begin
            gw_ff <= csr_data;
         end
         if (cmd.emit != EMIT_NONE) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_LOAD: begin
            x1_ff <= req_origin_x;
            y1_ff <= req_origin_y;
            a_ff  <= req_side_a;
            b_ff  <= req_side_b;
            c_ff  <= req_side_c;
         end
         OP_SQA: sqa_ff <= mul_p[13:0];
         OP_SQB: sqb_ff <= mul_p[13:0];
         OP_SQC: sqc_ff <= mul_p[13:0];
         OP_AB:  ab_ff  <= mul_p[13:0];
         OP_N:   n_ff   <= $signed(17'(sqa_ff)) + $signed(17'(sqb_ff)) - $signed(17'(sqc_ff));
         OP_T1:  t1_ff  <= {mul_p[29:0], 2'b00};
         OP_NN:  nn_ff  <= mul_p[31:0];
         OP_NX:  numx_ff <= mul_p[17:0] + 18'(n_ff);
         OP_DY:  dy_ff  <= mul_p[16:0];
         OP_DYSQ: dysq_ff <= mul_p[31:0];
         OP_D:   d_ff   <= ddiff[32] ? '0 : ddiff[31:0];
         OP_DIVX_INIT: begin
            numx_neg_ff <= numx_ff[17];
            dq_ff <= numx_ff[17] ? DIV_W'(-numx_ff) : numx_ff[DIV_W-1:0];
            dr_ff <= '0;
         end
         OP_DIV_STEP: begin
            dq_ff <= {dq_ff[DIV_W-2:0], sh_ge};
            dr_ff <= sh_ge ? 8'(sh - {1'b0, den}) : sh[7:0];
         end
         OP_X3: begin
            x3_ff <= numx_neg_ff ? -$signed(CW'(dq_ff[9:0])) : $signed(CW'(dq_ff[9:0]));
         end
         OP_SQRT_INIT: begin
            sq_src_ff  <= d_ff;
            sq_rem_ff  <= '0;
            sq_root_ff <= '0;
         end
         OP_SQRT_STEP: begin
            sq_src_ff <= {sq_src_ff[29:0], 2'b00};
            if (r4 >= trial) begin
               sq_rem_ff  <= r4 - trial;
               sq_root_ff <= {sq_root_ff[DIV_W-2:0], 1'b1};
            end else begin
               sq_rem_ff  <= r4;
               sq_root_ff <= {sq_root_ff[DIV_W-2:0], 1'b0};
            end
         end
         OP_DIVY_INIT: begin
            dq_ff <= sq_root_ff;
            dr_ff <= '0;
         end
         OP_Y3: y3_ff <= y1 - $signed(CW'(ycond ? ce : 9'(dq_ff[7:0])));
         OP_FULL: full_ff <= mul_p[16:0];
         OP_C1:  c1_ff  <= EW'(-mul_p);
         OP_C2A: tmp_ff <= mul_p[EW-1:0];
         OP_C2B: c2_ff  <= tmp_ff - mul_p[EW-1:0];
         OP_C3A: tmp_ff <= mul_p[EW-1:0];
         OP_C3B: c3_ff  <= tmp_ff - mul_p[EW-1:0];
         OP_BOX: begin
            r0_ff    <= r0;
            r1_ff    <= r1;
            c0_ff    <= c0;
            cl1_ff   <= c1;
            empty_ff <= (r0 > r1) || (c0 > c1);
         end
         OP_E1: begin
            e1_ff  <= mul_p[EW-1:0] + c1_ff;
            b1s_ff <= mul_p[EW-1:0] + c1_ff;
            py_ff  <= r0_ff[ROW_W-1:0];
         end
         OP_E2: begin
            e2_ff  <= mul_p[EW-1:0] + c2_ff;
            b2s_ff <= mul_p[EW-1:0] + c2_ff;
         end
         OP_E3: begin
            e3_ff  <= mul_p[EW-1:0] + c3_ff;
            b3s_ff <= mul_p[EW-1:0] + c3_ff;
         end
         OP_ROW_NEXT: begin
            e1_ff <= e1_ff + EW'(a_ff);
            e2_ff <= e2_ff + EW'(b2);
            e3_ff <= e3_ff + EW'(b3);
            py_ff <= py_ff + 1'b1;
         end
         OP_ROW_RESTART: begin
            e1_ff <= b1s_ff;
            e2_ff <= b2s_ff;
            e3_ff <= b3s_ff;
            py_ff <= r0_ff[ROW_W-1:0];
         end
         default: begin
         end
      endcase

      case (cmd.emit)
         EMIT_ROW: begin
            st_ff   <= STATUS_OK;
            row_ff  <= py_ff;
            mask_ff <= mask_w;
            last_ff <= row_last;
         end
         EMIT_INVALID: begin
            st_ff   <= STATUS_INVALID;
            row_ff  <= '0;
            mask_ff <= '0;
            last_ff <= 1'b1;
         end
         EMIT_EMPTY: begin
            st_ff   <= STATUS_EMPTY;
            row_ff  <= '0;
            mask_ff <= '0;
            last_ff <= 1'b1;
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = st_ff;
   assign rsp_row_index = row_ff;
   assign rsp_row_mask  = mask_ff;
   assign rsp_last      = last_ff;

   // A word is never loaded over one that the receiver is still holding off.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> (cmd.emit == EMIT_NONE))
      else $error("result word overwritten while stalled");

   // The final row of a command is flagged as the last word.
   a_last_row: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit == EMIT_ROW && row_last) |=> (rsp_valid_ff && last_ff))
      else $error("last row not flagged");

   // A visible box always lies inside the row range of the grid.
   a_box_in_grid: assert property (@(posedge clock) disable iff (reset)
      ($past(cmd.op == OP_BOX) && !empty_ff) |->
      (r0_ff >= 0 && r1_ff < $signed(CW'(MAX_ROWS))))
      else $error("clipped row span outside grid");

endmodule
